// ----- rtl/core/assert_macros.svh -----
// assert_macros.svh: assertion macros shared by the MurmurHash2 core RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MM2H_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MM2H_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/mm2h_pkg.sv -----
// mm2h_pkg: constants, types and helpers of the MurmurHash2 stream hash core.
// Used by mm2h_ctrl, mm2h_datapath and murmur2_32_stream_hash. No dependencies.
`default_nettype none

package mm2h_pkg;

    localparam logic [31:0] MIX_M = 32'h5bd1_e995;
    localparam int          MIX_R = 24;
    localparam int          FIN_A = 13;
    localparam int          FIN_B = 15;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KMUL,
        S_KMIX,
        S_HMIX,
        S_TAIL,
        S_FMUL,
        S_FOUT
    } t_state;

    typedef enum logic [2:0] {
        OP_WORD,
        OP_KMIX,
        OP_HMIX,
        OP_TAIL,
        OP_FIN
    } t_mul_op;

    typedef struct packed {
        logic    accept;
        logic    mul_en;
        t_mul_op op;
        logic    fin;
    } t_dp_cmd;

    typedef struct packed {
        logic in_word;
        logic in_tail;
        logic cur_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [WORD_W-1:0] tail_bytes(input logic [WORD_W-1:0] word,
                                                     input logic [1:0]        count);
        logic [WORD_W-1:0] t;
        case (count)
            2'd1:    t = {24'd0, word[7:0]};
            2'd2:    t = {16'd0, word[15:0]};
            default: t = {8'd0, word[23:0]};
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mm2h_datapath.sv -----
// mm2h_datapath: hash registers, shared 32-bit multiplier and output register.
// Depends on mm2h_pkg and assert_macros.svh; driven by mm2h_ctrl commands.
`default_nettype none
`include "assert_macros.svh"

module mm2h_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mm2h_pkg::t_dp_cmd           i_cmd,
    output mm2h_pkg::t_dp_status             o_status,
    input  wire logic [mm2h_pkg::WORD_W-1:0]  i_data_word,
    input  wire logic [mm2h_pkg::COUNT_W-1:0] i_byte_count,
    input  wire logic                        i_last_item,
    input  wire logic [mm2h_pkg::WORD_W-1:0]  i_total_length,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [mm2h_pkg::WORD_W-1:0]       o_hash_value
);
    import mm2h_pkg::*;

    logic [WORD_W-1:0]   r_word;
    logic [1:0]          r_count;
    logic                r_last;
    logic [WORD_W-1:0]   r_h;
    logic [WORD_W-1:0]   r_k;
    logic                r_open;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_hash;

    logic [WORD_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_lo;

    always_comb begin
        case (i_cmd.op)
            OP_WORD: mul_a = r_word;
            OP_KMIX: mul_a = r_k ^ (r_k >> MIX_R);
            OP_HMIX: mul_a = r_h;
            OP_TAIL: mul_a = r_h ^ tail_bytes(r_word, r_count);
            OP_FIN:  mul_a = r_h ^ (r_h >> FIN_A);
            default: mul_a = r_h;
        endcase
    end

    // low 32 bits of a 32x32 product
    assign mul_lo = mul_a * MIX_M;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_word  <= i_data_word;
            r_count <= i_byte_count[1:0];
            r_last  <= i_last_item;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.op)
                OP_WORD, OP_KMIX: r_k <= mul_lo;
                default:          r_k <= r_k;
            endcase
        end
        if (i_cmd.fin) begin
            r_hash <= r_h ^ (r_h >> FIN_B);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h         <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && !r_open) begin
                r_h    <= i_total_length;
                r_open <= 1'b1;
            end else if (i_cmd.fin) begin
                r_h    <= '0;
                r_open <= 1'b0;
            end else if (i_cmd.mul_en) begin
                case (i_cmd.op)
                    OP_HMIX:         r_h <= mul_lo ^ r_k;
                    OP_TAIL, OP_FIN: r_h <= mul_lo;
                    default:         r_h <= r_h;
                endcase
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.in_word  = !i_last_item || (i_byte_count >= COUNT_W'(4));
        o_status.in_tail  = i_last_item && (i_byte_count != '0) &&
                            (i_byte_count < COUNT_W'(4));
        o_status.cur_last = r_last;
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

    `MM2H_ASSERT(a_fin_needs_room, i_cmd.fin |-> o_status.out_free, "result overwritten")
    `MM2H_ASSERT(a_fin_closes_msg, i_cmd.fin |=> (!r_open && o_out_valid), "message not closed")

endmodule

`default_nettype wire

// ----- rtl/core/mm2h_ctrl.sv -----
// mm2h_ctrl: sequencer that steps one item through the shared multiplier.
// Depends on mm2h_pkg and assert_macros.svh; commands mm2h_datapath.
`default_nettype none
`include "assert_macros.svh"

module mm2h_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire mm2h_pkg::t_dp_status i_status,
    output mm2h_pkg::t_dp_cmd         o_cmd
);
    import mm2h_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.accept  = 1'b0;
        o_cmd.mul_en  = 1'b0;
        o_cmd.op      = OP_WORD;
        o_cmd.fin     = 1'b0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_word) begin
                        n_state = S_KMUL;
                    end else if (i_status.in_tail) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_FMUL;
                    end
                end
            end
            S_KMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_WORD;
                n_state      = S_KMIX;
            end
            S_KMIX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_KMIX;
                n_state      = S_HMIX;
            end
            S_HMIX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_HMIX;
                n_state      = i_status.cur_last ? S_FMUL : S_IDLE;
            end
            S_TAIL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_TAIL;
                n_state      = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.op     = OP_FIN;
                n_state      = S_FOUT;
            end
            S_FOUT: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `MM2H_ASSERT(a_word_done, (r_state == S_HMIX && !i_status.cur_last) |=> (r_state == S_IDLE), "word item not finished")
    `MM2H_ASSERT(a_fout_from_fmul, (r_state == S_FOUT && $past(r_state) != S_FOUT) |-> ($past(r_state) == S_FMUL), "finalize skipped")

endmodule

`default_nettype wire

// ----- rtl/core/murmur2_32_stream_hash.sv -----
// murmur2_32_stream_hash: top level of the streaming 32-bit MurmurHash2 (seed zero).
// Depends on mm2h_pkg, mm2h_ctrl and mm2h_datapath.
//
// One item is taken in the cycle in_stall is low, then run through a single shared
// 32x32 multiplier, one multiply per cycle, with the input stalled meanwhile.
// A non-last item (or a last one with four bytes) passes the accept state, then
// three multiplies (word, mixed word, running hash). A last item adds a finalize
// multiply and a load of the output register that waits while out_stall holds the
// previous result; a one-to-three-byte tail has one tail multiply in place of the
// three, an empty last item none. The first item of a message loads the running
// hash from total_length. The output register lets a new item be accepted while a
// finished hash waits to be taken.
`default_nettype none
`include "assert_macros.svh"

module murmur2_32_stream_hash (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [mm2h_pkg::WORD_W-1:0]  i_data_word,
    input  wire logic [mm2h_pkg::COUNT_W-1:0] i_byte_count,
    input  wire logic                         i_last_item,
    input  wire logic [mm2h_pkg::WORD_W-1:0]  i_total_length,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [mm2h_pkg::WORD_W-1:0]       o_hash_value
);
    import mm2h_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mm2h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    mm2h_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_data_word    (i_data_word),
        .i_byte_count   (i_byte_count),
        .i_last_item    (i_last_item),
        .i_total_length (i_total_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hash_value   (o_hash_value)
    );

    `MM2H_ASSERT_ALWAYS(a_accept_cmd, (dp_cmd.accept == (i_in_valid && !o_in_stall)), "accept mismatch")

endmodule

`default_nettype wire
